FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this core.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

FILE: rtl/core/dbu_pkg.sv
// Package of the dissemination barrier unit: sizes, word types, state codes,
// controller/datapath command and status structs and index helpers.
// Depends on nothing.
package dbu_pkg;

  localparam int MAX_THREADS = 64;
  localparam int MAX_ROUNDS  = 6;
  localparam int TID_W       = 6;
  localparam int CNT_W       = 7;
  localparam int RND_W       = 3;
  localparam int FLAG_DEPTH  = MAX_THREADS * MAX_ROUNDS * 2;
  localparam int FLAG_AW     = $clog2(FLAG_DEPTH);

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_THREADS);

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_POLL   = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [TID_W-1:0] thread_id;
  } item_t;

  typedef struct packed {
    logic [TID_W-1:0] thread_echo;
    logic             waiting;
    logic             released;
    logic [RND_W-1:0] round_reached;
    logic             error;
  } result_t;

  // Per-thread record held in the thread state RAM.
  typedef struct packed {
    logic             sense;
    logic             parity;
    logic [RND_W-1:0] round;
    logic             waiting;
    logic             psig;
  } tstate_t;

  localparam tstate_t TSTATE_RESET = '{sense: 1'b1, parity: 1'b0, round: '0,
                                       waiting: 1'b0, psig: 1'b0};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_SIGNAL,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic capture;
    logic set_error;
    logic arrive;
    logic signal;
    logic advance;
    logic release_thr;
    logic finish;
    logic clr_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_last;
    logic range_err;
    logic op_poll;
    logic waiting;
    logic round_lt;
    logic flag_match;
    logic last_round;
  } ctl_sts_t;

  // Zero acts as one, anything above the thread limit saturates.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (v == '0) c = CNT_W'(1);
    if (v > COUNT_RESET) c = COUNT_RESET;
    return c;
  endfunction

  // ceil(log2(c)), capped at MAX_ROUNDS.
  function automatic logic [RND_W-1:0] count_rounds(input logic [CNT_W-1:0] c);
    logic [RND_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if ((CNT_W'(1) << i) < c) lg = RND_W'(lg + RND_W'(1));
    end
    if (lg > RND_W'(MAX_ROUNDS)) lg = RND_W'(MAX_ROUNDS);
    return lg;
  endfunction

  // (thread * MAX_ROUNDS + round) * 2 + parity
  function automatic logic [FLAG_AW-1:0] flag_index(input logic [TID_W-1:0] t,
                                                    input logic [RND_W-1:0] r,
                                                    input logic p);
    logic [FLAG_AW-1:0] b;
    b = FLAG_AW'(FLAG_AW'(t) * FLAG_AW'(MAX_ROUNDS)) + FLAG_AW'(r);
    return {b[FLAG_AW-2:0], p};
  endfunction

endpackage

FILE: rtl/core/dbu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module dbu_ram #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dbu_ctrl.sv
// Controller of the dissemination barrier unit: sequences clear, load,
// per-round signal/check steps and result issue. Depends on dbu_pkg.
module dbu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dbu_pkg::ctl_sts_t sts,
  output dbu_pkg::ctl_cmd_t cmd,
  output logic              busy
);

  dbu_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbu_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dbu_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = dbu_pkg::ST_IDLE;
      end
      dbu_pkg::ST_IDLE: begin
        if (start) state_next = dbu_pkg::ST_LOAD;
      end
      dbu_pkg::ST_LOAD: state_next = dbu_pkg::ST_EVAL;
      dbu_pkg::ST_EVAL: begin
        if (!sts.range_err && sts.op_poll && sts.waiting && sts.round_lt) begin
          state_next = dbu_pkg::ST_SIGNAL;
        end else begin
          state_next = dbu_pkg::ST_DONE;
        end
      end
      dbu_pkg::ST_SIGNAL: state_next = dbu_pkg::ST_CHECK;
      dbu_pkg::ST_CHECK: begin
        if (sts.flag_match && !sts.last_round) begin
          state_next = dbu_pkg::ST_SIGNAL;
        end else begin
          state_next = dbu_pkg::ST_DONE;
        end
      end
      dbu_pkg::ST_DONE: state_next = dbu_pkg::ST_IDLE;
      default: state_next = dbu_pkg::ST_CLEAR;
    endcase
    if (sts.cfg_wr) state_next = dbu_pkg::ST_CLEAR;
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state != dbu_pkg::ST_IDLE);
    unique case (state)
      dbu_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      dbu_pkg::ST_IDLE:  cmd.accept = start;
      dbu_pkg::ST_LOAD:  cmd.capture = 1'b1;
      dbu_pkg::ST_EVAL: begin
        if (sts.range_err) begin
          cmd.set_error = 1'b1;
        end else if (!sts.op_poll) begin
          cmd.set_error = sts.waiting;
          cmd.arrive    = !sts.waiting;
        end else begin
          cmd.release_thr = sts.waiting && !sts.round_lt;
        end
      end
      dbu_pkg::ST_SIGNAL: cmd.signal = 1'b1;
      dbu_pkg::ST_CHECK: begin
        cmd.advance     = sts.flag_match;
        cmd.release_thr = sts.flag_match && sts.last_round;
      end
      dbu_pkg::ST_DONE: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/dbu_datapath.sv
// Datapath of the dissemination barrier unit: configuration, flag RAM,
// thread state RAM, working record and result word. Depends on dbu_pkg, dbu_ram.
module dbu_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dbu_pkg::CNT_W-1:0]  cfg_data,
  input  dbu_pkg::item_t             item,
  input  dbu_pkg::ctl_cmd_t          cmd,
  output dbu_pkg::ctl_sts_t          sts,
  output dbu_pkg::result_t           result,
  output logic                       done
);

  logic [dbu_pkg::CNT_W-1:0]   count;
  logic [dbu_pkg::RND_W-1:0]   nrounds;
  logic [dbu_pkg::CNT_W-1:0]   cfg_count;
  logic [dbu_pkg::FLAG_AW-1:0] clr_cnt;

  dbu_pkg::op_e                op_q;
  logic [dbu_pkg::TID_W-1:0]   tid_q;
  dbu_pkg::tstate_t            st;
  logic                        released_q;
  logic                        error_q;

  logic                        flag_we;
  logic [dbu_pkg::FLAG_AW-1:0] flag_waddr;
  logic                        flag_wdata;
  logic [dbu_pkg::FLAG_AW-1:0] flag_raddr;
  logic                        flag_rdata;

  logic                            st_we;
  logic [dbu_pkg::TID_W-1:0]       st_waddr;
  logic [$bits(dbu_pkg::tstate_t)-1:0] st_wdata;
  logic [$bits(dbu_pkg::tstate_t)-1:0] st_rdata;

  logic [dbu_pkg::CNT_W-1:0]   partner_sum;
  logic [dbu_pkg::CNT_W-1:0]   partner_wrap;
  logic [dbu_pkg::TID_W-1:0]   partner;
  logic                        range_err;

  assign cfg_count = dbu_pkg::clamp_count(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= dbu_pkg::COUNT_RESET;
      nrounds <= dbu_pkg::count_rounds(dbu_pkg::COUNT_RESET);
      clr_cnt <= '0;
    end else if (cfg_we) begin
      count   <= cfg_count;
      nrounds <= dbu_pkg::count_rounds(cfg_count);
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= dbu_pkg::FLAG_AW'(clr_cnt + dbu_pkg::FLAG_AW'(1));
    end
  end

  // Partner is (t + 2^r) mod count; both terms are below count.
  assign partner_sum  = dbu_pkg::CNT_W'({1'b0, tid_q}) +
                        (dbu_pkg::CNT_W'(1) << st.round);
  assign partner_wrap = (partner_sum >= count) ?
                        dbu_pkg::CNT_W'(partner_sum - count) : partner_sum;
  assign partner      = partner_wrap[dbu_pkg::TID_W-1:0];
  assign range_err    = (dbu_pkg::CNT_W'({1'b0, tid_q}) >= count);

  // Flag RAM: cleared by the sweep, written with the partner flag.
  assign flag_we    = cmd.clr_step || (cmd.signal && !st.psig);
  assign flag_waddr = cmd.clr_step ? clr_cnt :
                      dbu_pkg::flag_index(partner, st.round, st.parity);
  assign flag_wdata = cmd.clr_step ? 1'b0 : st.sense;
  assign flag_raddr = dbu_pkg::flag_index(tid_q, st.round, st.parity);

  dbu_ram #(
    .WIDTH (1),
    .DEPTH (dbu_pkg::FLAG_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  // Thread state RAM: the sweep resets all its rows, finish writes back.
  assign st_we    = (cmd.clr_step &&
                     (clr_cnt < dbu_pkg::FLAG_AW'(dbu_pkg::MAX_THREADS))) || cmd.finish;
  assign st_waddr = cmd.clr_step ? clr_cnt[dbu_pkg::TID_W-1:0] : tid_q;
  assign st_wdata = cmd.clr_step ? dbu_pkg::TSTATE_RESET : st;

  dbu_ram #(
    .WIDTH ($bits(dbu_pkg::tstate_t)),
    .DEPTH (dbu_pkg::MAX_THREADS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (item.thread_id),
    .rdata (st_rdata)
  );

  // Working record of the thread in flight.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= item.op;
      tid_q <= item.thread_id;
    end
    if (cmd.capture) begin
      st         <= dbu_pkg::tstate_t'(st_rdata);
      released_q <= 1'b0;
      error_q    <= 1'b0;
    end
    if (cmd.set_error) error_q <= 1'b1;
    if (cmd.arrive) begin
      st.waiting <= 1'b1;
      st.round   <= '0;
      st.psig    <= 1'b0;
    end
    if (cmd.signal) st.psig <= 1'b1;
    if (cmd.advance) begin
      st.round <= dbu_pkg::RND_W'(st.round + dbu_pkg::RND_W'(1));
    end
    if (cmd.release_thr) begin
      st.sense   <= st.sense ^ st.parity;
      st.parity  <= ~st.parity;
      st.waiting <= 1'b0;
      released_q <= 1'b1;
    end
    // Drop the signalled mark on leaving a round or the barrier.
    if (cmd.advance || cmd.release_thr) st.psig <= 1'b0;
  end

  always_comb begin
    sts            = '0;
    sts.cfg_wr     = cfg_we;
    sts.clr_last   = (clr_cnt == dbu_pkg::FLAG_AW'(dbu_pkg::FLAG_DEPTH - 1));
    sts.range_err  = range_err;
    sts.op_poll    = (op_q == dbu_pkg::OP_POLL);
    sts.waiting    = st.waiting;
    sts.round_lt   = (st.round < nrounds);
    sts.flag_match = (flag_rdata == st.sense);
    sts.last_round = (dbu_pkg::RND_W'(st.round + dbu_pkg::RND_W'(1)) >= nrounds);
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.thread_echo <= tid_q;
      if (range_err) begin
        result.waiting       <= 1'b0;
        result.released      <= 1'b0;
        result.round_reached <= '0;
        result.error         <= 1'b1;
      end else begin
        result.waiting       <= st.waiting;
        result.released      <= released_q;
        result.round_reached <= st.round;
        result.error         <= error_q;
      end
    end
  end

endmodule

FILE: rtl/core/dissemination_barrier_unit.sv
// Top level of the dissemination barrier unit: controller plus datapath.
// Depends on dbu_pkg, dbu_ctrl, dbu_datapath (and dbu_ram below it).
//
// Usage: raise start with an item word (op, thread_id) while busy is low; the
// word is taken at that edge. Exactly one result word follows, on result for a
// single cycle with done high; the receiver cannot stall it, so capture it on
// that edge. An arrive passes through the load, evaluate and done states before
// the next word can be accepted; a poll also walks through the barrier rounds
// that it reaches (at most 6 for 64 threads). Each round costs a flag-RAM
// write-and-read step and a compare step, since the flag store has a single
// write port and a registered read. The result appears in the first cycle
// that busy is low. After reset, and after every thread_count write, the unit
// sweeps the 768-entry flag store and the 64-entry thread state store clear,
// one entry a cycle, with busy high throughout. thread_count is accepted at
// any edge with cfg_valid high (cfg_ready is always high), but write it only
// while no item is in flight; a write restarts the sweep.
module dissemination_barrier_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  dbu_pkg::item_t            item,
  output logic                      done,
  output dbu_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dbu_pkg::CNT_W-1:0] cfg_data
);

  dbu_pkg::ctl_cmd_t cmd;
  dbu_pkg::ctl_sts_t sts;
  logic              cfg_we;

  // Configuration is never held off.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequence the item: load record, evaluate, walk rounds, write back.
  dbu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold configuration, flags and thread records; form the result word.
  dbu_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result),
    .done     (done)
  );

endmodule

FILE: rtl/core/dbu_checker.sv
// Port-level checker of the dissemination barrier unit, bound to the top level.
// Depends on dbu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbu_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input dbu_pkg::result_t result
);

  logic err_out;

  // Error reported from outside the barrier.
  assign err_out = done && result.error && !result.waiting;

  // An accepted word keeps the unit busy in the next cycle.
  `ASSERT_HOLDS(a_accept_busy, clk, rst, start && !busy |=> busy, "accept without busy")

  // A result only follows a busy cycle.
  `ASSERT_HOLDS(a_done_after_busy, clk, rst, done |-> $past(busy), "result out of nowhere")

  // A thread cannot be released and still waiting.
  `ASSERT_NEVER(a_rel_wait, clk, rst, done && result.released && result.waiting, "still waiting")

  // An error outside the barrier reports round zero.
  `ASSERT_NEVER(a_err_round, clk, rst, err_out && result.round_reached != '0, "error round")

endmodule

bind dissemination_barrier_unit dbu_checker u_dbu_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the dissemination barrier unit: plays arrive and poll words
// against a behavioural barrier kept in the bench and checks every result word field by
// field. Depends on dbu_pkg and dissemination_barrier_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dbu_pkg::*;

  // Ports of the unit; its inputs are all driven from time zero.
  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             done;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  dissemination_barrier_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioural barrier: a private copy of the flags and per-thread records,
  // advanced once for every word the unit accepts.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] live_count;
  int unsigned      live_rounds;
  bit               round_flag    [FLAG_DEPTH];
  bit               thr_sense     [MAX_THREADS];
  bit               thr_parity    [MAX_THREADS];
  bit               thr_waiting   [MAX_THREADS];
  bit               thr_signalled [MAX_THREADS];
  logic [RND_W-1:0] thr_round     [MAX_THREADS];

  // Result words the unit still owes, oldest first.
  result_t replies_due [$];
  int      mismatch_count = 0;

  // Slot of the flag owned by thread t for round r under parity p.
  function automatic int unsigned flag_slot(int unsigned t, int unsigned r, bit p);
    return (t * MAX_ROUNDS + r) * 2 + p;
  endfunction

  // A thread_count write: clamp the count, derive the round count, wipe everything.
  function automatic void barrier_reinit(logic [CNT_W-1:0] value);
    logic [CNT_W-1:0] c;
    c = value;
    if (c == '0) c = CNT_W'(1);
    if (c > CNT_W'(MAX_THREADS)) c = CNT_W'(MAX_THREADS);
    live_count  = c;
    live_rounds = 0;
    while (live_rounds < MAX_ROUNDS && (1 << live_rounds) < c) live_rounds++;
    foreach (round_flag[i]) round_flag[i] = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      thr_sense[i]     = 1'b1;
      thr_parity[i]    = 1'b0;
      thr_waiting[i]   = 1'b0;
      thr_signalled[i] = 1'b0;
      thr_round[i]     = '0;
    end
  endfunction

  // Apply one word to the barrier and return the result word it should give.
  function automatic result_t barrier_step(item_t w);
    result_t     o;
    int unsigned t;
    int unsigned r;
    int unsigned buddy;
    bit          par;
    bit          sen;
    bit          stuck;
    o = '0;
    o.thread_echo = w.thread_id;
    t = 32'(w.thread_id);
    if (t >= live_count) begin
      // Outside the configured thread set: flag it and leave the state alone.
      o.error = 1'b1;
    end else if (w.op == OP_ARRIVE) begin
      if (thr_waiting[t]) begin
        o.error   = 1'b1;
        o.waiting = 1'b1;
      end else begin
        thr_waiting[t]   = 1'b1;
        thr_round[t]     = '0;
        thr_signalled[t] = 1'b0;
        o.waiting        = 1'b1;
      end
      o.round_reached = thr_round[t];
    end else begin
      if (thr_waiting[t]) begin
        par   = thr_parity[t];
        sen   = thr_sense[t];
        r     = 32'(thr_round[t]);
        stuck = 1'b0;
        // Signal the partner once per round, then pass while our own flag agrees.
        while (r < live_rounds && !stuck) begin
          if (!thr_signalled[t]) begin
            buddy = (t + (1 << r)) % live_count;
            round_flag[flag_slot(buddy, r, par)] = sen;
            thr_signalled[t] = 1'b1;
          end
          if (round_flag[flag_slot(t, r, par)] != sen) begin
            stuck = 1'b1;
          end else begin
            r++;
            thr_signalled[t] = 1'b0;
          end
        end
        thr_round[t] = RND_W'(r);
        if (r >= live_rounds) begin
          // Last round passed: sense turns over on every second episode.
          if (par) thr_sense[t] = ~sen;
          thr_parity[t]    = ~par;
          thr_waiting[t]   = 1'b0;
          thr_signalled[t] = 1'b0;
          o.released       = 1'b1;
        end else begin
          o.waiting = 1'b1;
        end
      end
      o.round_reached = thr_round[t];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script. Replies are typed in only where they are obvious; the rest
  // come from the behavioural barrier.
  // ---------------------------------------------------------------------------
  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CNT_W-1:0] count;
    item_t            word;
    logic             typed;
    result_t          reply;
  } row_t;

  localparam result_t NO_REPLY   = '0;
  localparam int      SCRIPT_LEN = 26;

  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    // Full 64-thread set out of reset: poll of an idle thread changes nothing.
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b1, '{6'd0,  1'b0, 1'b0, 3'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd63}, 1'b1, '{6'd63, 1'b1, 1'b0, 3'd0, 1'b0}},
    // Second arrive while still inside the barrier.
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd63}, 1'b1, '{6'd63, 1'b1, 1'b0, 3'd0, 1'b1}},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd63}, 1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd0},  1'b1, '{6'd0,  1'b1, 1'b0, 3'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b0, NO_REPLY},
    // Count of zero behaves as a single thread: no rounds at all.
    '{ROW_CFG,  7'd0, '{OP_ARRIVE, 6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd0},  1'b1, '{6'd0,  1'b1, 1'b0, 3'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b1, '{6'd0,  1'b0, 1'b1, 3'd0, 1'b0}},
    // Ids beyond the set.
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd1},  1'b1, '{6'd1,  1'b0, 1'b0, 3'd0, 1'b1}},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd63}, 1'b1, '{6'd63, 1'b0, 1'b0, 3'd0, 1'b1}},
    // Odd-parity episode: sense turns over on release.
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b1, '{6'd0,  1'b0, 1'b0, 3'd0, 1'b0}},
    // Two threads, one round; last poll hits a released thread.
    '{ROW_CFG,  7'd2, '{OP_ARRIVE, 6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd1},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd1},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd0},  1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd1},  1'b0, NO_REPLY},
    // All-ones count saturates to the full set.
    '{ROW_CFG,  7'd127, '{OP_ARRIVE, 6'd0}, 1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd63}, 1'b1, '{6'd63, 1'b1, 1'b0, 3'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd63}, 1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_ARRIVE, 6'd32}, 1'b0, NO_REPLY},
    '{ROW_ITEM, 7'd0, '{OP_POLL,   6'd32}, 1'b0, NO_REPLY}
  };

  // Random phases: thread counts visited, extremes included.
  localparam int               PHASES = 12;
  localparam logic [CNT_W-1:0] PHASE_COUNT [PHASES] = '{
    7'd1, 7'd3, 7'd64, 7'd5, 7'd2, 7'd127, 7'd17, 7'd8, 7'd0, 7'd40, 7'd33, 7'd4
  };

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until taken, then book its reply. Start stays
  // high afterwards so a following word can go straight in.
  task automatic issue_word(input item_t w, input logic typed, input result_t reply);
    result_t predicted;
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    predicted = barrier_step(w);
    replies_due.push_back(typed ? reply : predicted);
  endtask

  // Drop start for a random stretch, with the given chance in a hundred.
  task automatic maybe_idle(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every booked reply has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write thread_count with the unit idle; the unit then sweeps its stores.
  task automatic write_thread_count(input logic [CNT_W-1:0] v);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    barrier_reinit(v);
  endtask

  initial begin : stimulus
    item_t       w;
    int unsigned cursor;
    int unsigned n;
    int unsigned pct;

    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    barrier_reinit(COUNT_RESET);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed script; the clearing sweep after reset simply shows up as busy.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        write_thread_count(SCRIPT[i].count);
      end else begin
        issue_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].reply);
        maybe_idle(14);
      end
    end

    // Random phases. Most words follow a thread cursor that walks the set, so
    // each thread arrives and then keeps polling until it is let through;
    // the rest are noise over the whole id and op space.
    for (int ph = 0; ph < PHASES; ph++) begin
      pct = (ph < 4) ? 14 : (ph < 8) ? 45 : 0;
      write_thread_count(PHASE_COUNT[ph]);
      n      = 40 + 5 * live_count;
      cursor = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(99) < 80) begin
          w.thread_id = TID_W'(cursor);
          w.op        = thr_waiting[cursor] ? OP_POLL : OP_ARRIVE;
          // Advance mostly in order, now and then jump ahead.
          cursor = (cursor + 1 + (($urandom_range(3) == 0) ? $urandom_range(live_count - 1) : 0))
                   % live_count;
        end else begin
          w.op        = $urandom_range(1) ? OP_POLL : OP_ARRIVE;
          w.thread_id = TID_W'($urandom_range(MAX_THREADS - 1));
        end
        issue_word(w, 1'b0, NO_REPLY);
        if (i == n / 2) hold_until_drained();
        else maybe_idle(pct);
      end
    end

    // Let the last replies in, then allow for any stray word.
    hold_until_drained();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: a result word lives for one cycle, so take it on that edge.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : reply_check
    result_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 60)
          $display("%0t ns: result word with none outstanding, expected nothing, got %h",
                   $time, result);
      end else begin
        want = replies_due.pop_front();
        if (result.thread_echo !== want.thread_echo)
          note_mismatch("thread_echo", 8'(want.thread_echo), 8'(result.thread_echo));
        if (result.waiting !== want.waiting)
          note_mismatch("waiting", 8'(want.waiting), 8'(result.waiting));
        if (result.released !== want.released)
          note_mismatch("released", 8'(want.released), 8'(result.released));
        if (result.round_reached !== want.round_reached)
          note_mismatch("round_reached", 8'(want.round_reached), 8'(result.round_reached));
        if (result.error !== want.error)
          note_mismatch("error", 8'(want.error), 8'(result.error));
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dbu_pkg.sv
rtl/core/dbu_ram.sv
rtl/core/dbu_ctrl.sv
rtl/core/dbu_datapath.sv
rtl/core/dissemination_barrier_unit.sv
rtl/core/dbu_checker.sv
bench/tb_top.sv
